// ===== design/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared sizes, codes and helpers for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;

  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int POS_W  = 11;
  localparam int CELL_W = 16;
  localparam int ADDR_W = $clog2(CELL_COUNT);

  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_SETXY = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] CH_BLANK     = 8'h20;

  localparam logic [7:0] ATTR_RESET = 8'h07;
  localparam int         TAB_STOP   = 8;

  // Outcome of a put command for the current cursor.
  typedef struct packed {
    logic             we;
    logic [COL_W-1:0] wr_col;
    logic [7:0]       wr_char;
    logic [ROW_W-1:0] row_next;
    logic [COL_W-1:0] col_next;
    logic             scroll;
  } put_ctl_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    int lin;
    lin = int'(r) * COLUMNS + int'(c);
    return ADDR_W'(lin);
  endfunction

  function automatic logic [POS_W-1:0] lin_pos(input logic [ROW_W-1:0] r,
                                               input logic [COL_W-1:0] c);
    int lin;
    lin = int'(r) * COLUMNS + int'(c);
    return POS_W'(lin);
  endfunction

endpackage

// ===== design/tcw_cursor.sv =====
// ----------------------------------------------------------------------------
// tcw_cursor
// Put-character decode: cell write and cursor motion for one character.
// ----------------------------------------------------------------------------
module tcw_cursor (
  input  logic [tcw_pkg::ROW_W-1:0] cur_row,
  input  logic [tcw_pkg::COL_W-1:0] cur_col,
  input  logic [7:0]                char_code,
  output tcw_pkg::put_ctl_t         ctl
);
  import tcw_pkg::*;

  localparam int SUM_W = COL_W + 1;

  logic [SUM_W-1:0] col_inc;
  logic [SUM_W-1:0] col_tab;
  logic             last_row;
  logic [ROW_W-1:0] row_down;

  assign col_inc  = {1'b0, cur_col} + SUM_W'(1);
  assign col_tab  = ({1'b0, cur_col} + SUM_W'(TAB_STOP)) & ~SUM_W'(TAB_STOP - 1);
  assign last_row = (cur_row == ROW_W'(ROWS - 1));
  // at the bottom line the row stays put and the screen scrolls instead
  assign row_down = last_row ? cur_row : cur_row + ROW_W'(1);

  always_comb begin
    ctl          = '0;
    ctl.wr_col   = cur_col;
    ctl.wr_char  = char_code;
    ctl.row_next = cur_row;
    ctl.col_next = cur_col;
    case (char_code)
      CH_NEWLINE: begin
        ctl.row_next = row_down;
        ctl.col_next = '0;
        ctl.scroll   = last_row;
      end
      CH_RETURN: begin
        ctl.col_next = '0;
      end
      CH_TAB: begin
        if (col_tab >= SUM_W'(COLUMNS)) begin
          ctl.row_next = row_down;
          ctl.col_next = '0;
          ctl.scroll   = last_row;
        end else begin
          ctl.col_next = col_tab[COL_W-1:0];
        end
      end
      CH_BACKSPACE: begin
        if (cur_col != '0) begin
          ctl.we       = 1'b1;
          ctl.wr_col   = cur_col - COL_W'(1);
          ctl.wr_char  = CH_BLANK;
          ctl.col_next = cur_col - COL_W'(1);
        end
      end
      default: begin
        ctl.we = 1'b1;
        if (col_inc >= SUM_W'(COLUMNS)) begin
          ctl.row_next = row_down;
          ctl.col_next = '0;
          ctl.scroll   = last_row;
        end else begin
          ctl.col_next = col_inc[COL_W-1:0];
        end
      end
    endcase
  end

endmodule

// ===== design/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_writer
// Text console engine over a ROWS x COLUMNS screen memory of 16-bit cells.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive command, char_code, row, col and raise start; the
//   item is taken at an edge with start high and busy low.
//   Result: done pulses for one cycle with cursor_row, cursor_col,
//   cursor_position, cell_data and scrolled valid; the receiver cannot stall.
//   Attribute: cfg_data is written at an edge with cfg_valid and cfg_ready
//   high; cfg_ready is always high. Write it only while no command is open.
// Sequence:
//   put without scroll and set cursor: done in the cycle after the accept.
//   read cell: S_READ takes the registered memory read and raises done.
//   clear, and put that scrolls: one sweep over the screen memory, one cell
//   a cycle through the single write port, then S_FINISH raises done.
//   busy stays high until the sweep is drained.
// Reset: cursor home, attribute 0x07, no result pending. The screen memory
//   is not cleared; issue a clear before reading cells.
// ----------------------------------------------------------------------------
module text_console_writer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 command,
  input  logic [7:0]                 char_code,
  input  logic [tcw_pkg::ROW_W-1:0]  row,
  input  logic [tcw_pkg::COL_W-1:0]  col,
  output logic                       done,
  output logic [tcw_pkg::ROW_W-1:0]  cursor_row,
  output logic [tcw_pkg::COL_W-1:0]  cursor_col,
  output logic [tcw_pkg::POS_W-1:0]  cursor_position,
  output logic [tcw_pkg::CELL_W-1:0] cell_data,
  output logic                       scrolled,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [7:0]                 cfg_data
);
  import tcw_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_READ   = 2'd1;
  localparam logic [1:0] S_SWEEP  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  localparam int NXT_W = ADDR_W + 1;

  logic [1:0]        state;
  logic [ADDR_W-1:0] idx;
  logic              wr_go;
  logic [ADDR_W-1:0] wr_addr;
  logic              wr_blank;
  logic              sweep_clear;
  logic [ROW_W-1:0]  cur_row;
  logic [COL_W-1:0]  cur_col;
  logic [7:0]        text_attribute;
  logic [CELL_W-1:0] rd_data;
  logic [CELL_W-1:0] mem [CELL_COUNT];

  put_ctl_t          ctl;
  logic              accept;
  logic [ROW_W-1:0]  row_clamp;
  logic [COL_W-1:0]  col_clamp;
  logic [NXT_W-1:0]  idx_src;
  logic [ADDR_W-1:0] rd_addr;
  logic              put_we;
  logic [ADDR_W-1:0] put_addr;
  logic [CELL_W-1:0] blank_cell;

  tcw_cursor u_cursor (
    .cur_row   (cur_row),
    .cur_col   (cur_col),
    .char_code (char_code),
    .ctl       (ctl)
  );

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign cfg_ready  = 1'b1;
  assign blank_cell = {text_attribute, CH_BLANK};

  assign row_clamp = (row > ROW_W'(ROWS - 1)) ? ROW_W'(ROWS - 1) : row;
  assign col_clamp = (col > COL_W'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1) : col;

  // scroll source is one row below; past the end the read is don't-care
  assign idx_src = {1'b0, idx} + NXT_W'(COLUMNS);
  assign rd_addr = (state == S_IDLE) ? cell_addr(row_clamp, col_clamp) :
                   (idx_src < NXT_W'(CELL_COUNT)) ? idx_src[ADDR_W-1:0] : idx;

  assign put_we   = accept && (command == CMD_PUT) && ctl.we;
  assign put_addr = cell_addr(cur_row, ctl.wr_col);

  assign cursor_row      = cur_row;
  assign cursor_col      = cur_col;
  assign cursor_position = lin_pos(cur_row, cur_col);

  // screen memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_go) begin
      mem[wr_addr] <= wr_blank ? blank_cell : rd_data;
    end else if (put_we) begin
      mem[put_addr] <= {text_attribute, ctl.wr_char};
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= ATTR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      text_attribute <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr  <= idx;
    wr_blank <= sweep_clear || (idx >= ADDR_W'(CELL_COUNT - COLUMNS));
    if (rst) begin
      state       <= S_IDLE;
      idx         <= '0;
      wr_go       <= 1'b0;
      sweep_clear <= 1'b0;
      cur_row     <= '0;
      cur_col     <= '0;
      done        <= 1'b0;
      cell_data   <= '0;
      scrolled    <= 1'b0;
    end else begin
      done  <= 1'b0;
      wr_go <= (state == S_SWEEP);
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cell_data <= '0;
            scrolled  <= 1'b0;
            idx       <= '0;
            unique case (command)
              CMD_PUT: begin
                cur_row     <= ctl.row_next;
                cur_col     <= ctl.col_next;
                sweep_clear <= 1'b0;
                if (ctl.scroll) begin
                  state <= S_SWEEP;
                end else begin
                  done <= 1'b1;
                end
              end
              CMD_CLEAR: begin
                cur_row     <= '0;
                cur_col     <= '0;
                sweep_clear <= 1'b1;
                state       <= S_SWEEP;
              end
              CMD_SETXY: begin
                cur_row <= row_clamp;
                cur_col <= col_clamp;
                done    <= 1'b1;
              end
              CMD_READ: begin
                state <= S_READ;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_READ: begin
          cell_data <= rd_data;
          done      <= 1'b1;
          state     <= S_IDLE;
        end
        S_SWEEP: begin
          if (idx == ADDR_W'(CELL_COUNT - 1)) begin
            state <= S_FINISH;
          end else begin
            idx <= idx + ADDR_W'(1);
          end
        end
        S_FINISH: begin
          // last pending cell write lands at this edge
          done     <= 1'b1;
          scrolled <= !sweep_clear;
          state    <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while a command is still open");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (cur_row < ROW_W'(ROWS)) && (cur_col < COL_W'(COLUMNS)))
    else $error("cursor outside the screen");

  a_sweep_owns_port: assert property (@(posedge clk) disable iff (rst)
    wr_go |-> ((state == S_SWEEP) || (state == S_FINISH)) && !put_we)
    else $error("sweep write collides with a put write");

  a_scroll_cursor: assert property (@(posedge clk) disable iff (rst)
    (done && scrolled) |-> (cur_row == ROW_W'(ROWS - 1)) && (cur_col == '0))
    else $error("scroll left the cursor off the bottom line start");

  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    (accept && (command == CMD_READ)) |=> (state == S_READ) ##1 done)
    else $error("read result not delivered two cycles after accept");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for text_console_writer: a table of directed commands,
// then random command streams under several text attributes. Each command is
// run through a local console model at the accept edge, and each done pulse
// is checked against the oldest predicted cursor/cell result.
// ----------------------------------------------------------------------------
module tb;
  import tcw_pkg::*;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [POS_W-1:0]  pos;
    logic [CELL_W-1:0] cell_val;
    logic              scr;
  } console_res_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [7:0]       ch;
    logic [ROW_W-1:0] r;
    logic [COL_W-1:0] c;
    logic             typed;
    console_res_t     res;
  } plan_t;

  localparam int PLAN_LEN    = 24;
  localparam int STALL_LIMIT = 4 * (CELL_COUNT + 16) + 100;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        command = CMD_PUT;
  logic [7:0]        char_code = 8'd0;
  logic [ROW_W-1:0]  row = '0;
  logic [COL_W-1:0]  col = '0;
  logic              done;
  logic [ROW_W-1:0]  cursor_row;
  logic [COL_W-1:0]  cursor_col;
  logic [POS_W-1:0]  cursor_position;
  logic [CELL_W-1:0] cell_data;
  logic              scrolled;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [7:0]        cfg_data = 8'd0;

  // console shadow state
  logic [CELL_W-1:0] screen [CELL_COUNT];
  int                cur_r;
  int                cur_c;
  logic [7:0]        attr;

  console_res_t      pending_results[$];
  int                mismatches;
  int                stall_cycles;
  bit                idling;

  // typed rows: reset state, clamping, scroll at the corner, backspace at
  // column 0, tab past the last stop
  plan_t plan [PLAN_LEN] = '{
    '{CMD_PUT,   8'h41,        5'd0,  7'd0,   1'b1, '{5'd0,  7'd1,  11'd1,    16'h0000, 1'b0}},
    '{CMD_CLEAR, 8'h00,        5'd0,  7'd0,   1'b1, '{5'd0,  7'd0,  11'd0,    16'h0000, 1'b0}},
    '{CMD_READ,  8'h00,        5'd31, 7'd127, 1'b1, '{5'd0,  7'd0,  11'd0,    16'h0720, 1'b0}},
    '{CMD_SETXY, 8'h00,        5'd31, 7'd127, 1'b1, '{5'd24, 7'd79, 11'd1999, 16'h0000, 1'b0}},
    '{CMD_PUT,   8'hFF,        5'd0,  7'd0,   1'b1, '{5'd24, 7'd0,  11'd1920, 16'h0000, 1'b1}},
    '{CMD_READ,  8'h00,        5'd23, 7'd79,  1'b1, '{5'd24, 7'd0,  11'd1920, 16'h07FF, 1'b0}},
    '{CMD_READ,  8'h00,        5'd24, 7'd0,   1'b1, '{5'd24, 7'd0,  11'd1920, 16'h0720, 1'b0}},
    '{CMD_PUT,   CH_BACKSPACE, 5'd0,  7'd0,   1'b1, '{5'd24, 7'd0,  11'd1920, 16'h0000, 1'b0}},
    '{CMD_PUT,   8'h00,        5'd0,  7'd0,   1'b1, '{5'd24, 7'd1,  11'd1921, 16'h0000, 1'b0}},
    '{CMD_PUT,   CH_BACKSPACE, 5'd0,  7'd0,   1'b1, '{5'd24, 7'd0,  11'd1920, 16'h0000, 1'b0}},
    '{CMD_READ,  8'h00,        5'd24, 7'd0,   1'b1, '{5'd24, 7'd0,  11'd1920, 16'h0720, 1'b0}},
    '{CMD_SETXY, 8'h00,        5'd0,  7'd75,  1'b1, '{5'd0,  7'd75, 11'd75,   16'h0000, 1'b0}},
    '{CMD_PUT,   CH_TAB,       5'd0,  7'd0,   1'b1, '{5'd1,  7'd0,  11'd80,   16'h0000, 1'b0}},
    '{CMD_SETXY, 8'h00,        5'd3,  7'd8,   1'b1, '{5'd3,  7'd8,  11'd248,  16'h0000, 1'b0}},
    '{CMD_PUT,   CH_TAB,       5'd0,  7'd0,   1'b0, '0},
    '{CMD_PUT,   CH_RETURN,    5'd0,  7'd0,   1'b0, '0},
    '{CMD_PUT,   CH_NEWLINE,   5'd0,  7'd0,   1'b0, '0},
    '{CMD_SETXY, 8'h00,        5'd24, 7'd40,  1'b0, '0},
    '{CMD_PUT,   CH_NEWLINE,   5'd0,  7'd0,   1'b1, '{5'd24, 7'd0,  11'd1920, 16'h0000, 1'b1}},
    '{CMD_SETXY, 8'h00,        5'd24, 7'd72,  1'b0, '0},
    '{CMD_PUT,   CH_TAB,       5'd0,  7'd0,   1'b1, '{5'd24, 7'd0,  11'd1920, 16'h0000, 1'b1}},
    '{CMD_READ,  8'h00,        5'd0,  7'd0,   1'b0, '0},
    '{CMD_PUT,   8'h7F,        5'd31, 7'd127, 1'b0, '0},
    '{CMD_READ,  8'h00,        5'd0,  7'd127, 1'b0, '0}
  };

  text_console_writer dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .command         (command),
    .char_code       (char_code),
    .row             (row),
    .col             (col),
    .done            (done),
    .cursor_row      (cursor_row),
    .cursor_col      (cursor_col),
    .cursor_position (cursor_position),
    .cell_data       (cell_data),
    .scrolled        (scrolled),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  always #6 clk = ~clk;

  // clamped linear cell index for set-cursor and read
  function automatic int cell_of(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c);
    int rr;
    int cc;
    rr = (int'(r) > ROWS - 1) ? ROWS - 1 : int'(r);
    cc = (int'(c) > COLUMNS - 1) ? COLUMNS - 1 : int'(c);
    return rr * COLUMNS + cc;
  endfunction

  // column 0 of the next line, scrolling up one row at the bottom
  function automatic logic line_feed();
    cur_c = 0;
    cur_r++;
    if (cur_r < ROWS) return 1'b0;
    for (int i = 0; i < CELL_COUNT - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
    for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) screen[i] = {attr, CH_BLANK};
    cur_r = ROWS - 1;
    return 1'b1;
  endfunction

  function automatic console_res_t console_step(input logic [1:0] cmd, input logic [7:0] ch,
                                                input logic [ROW_W-1:0] r_in,
                                                input logic [COL_W-1:0] c_in);
    console_res_t res;
    logic         scr;
    int           idx;
    res = '0;
    scr = 1'b0;
    idx = cell_of(r_in, c_in);
    case (cmd)
      CMD_PUT: begin
        if (ch == CH_NEWLINE) begin
          scr = line_feed();
        end else if (ch == CH_RETURN) begin
          cur_c = 0;
        end else if (ch == CH_TAB) begin
          cur_c = (cur_c + TAB_STOP) & ~(TAB_STOP - 1);
          if (cur_c >= COLUMNS) scr = line_feed();
        end else if (ch == CH_BACKSPACE) begin
          if (cur_c > 0) begin
            cur_c--;
            screen[cur_r * COLUMNS + cur_c] = {attr, CH_BLANK};
          end
        end else begin
          screen[cur_r * COLUMNS + cur_c] = {attr, ch};
          cur_c++;
          if (cur_c >= COLUMNS) scr = line_feed();
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < CELL_COUNT; i++) screen[i] = {attr, CH_BLANK};
        cur_r = 0;
        cur_c = 0;
      end
      CMD_SETXY: begin
        cur_r = idx / COLUMNS;
        cur_c = idx % COLUMNS;
      end
      default: res.cell_val = screen[idx];
    endcase
    res.row = ROW_W'(cur_r);
    res.col = COL_W'(cur_c);
    res.pos = POS_W'(cur_r * COLUMNS + cur_c);
    res.scr = scr;
    return res;
  endfunction

  // Called at the accept edge of the previous item (or any edge while idle);
  // start is only raised here, never lowered and raised in one step.
  task automatic issue(input logic [1:0] cmd, input logic [7:0] ch,
                       input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c,
                       input logic typed, input console_res_t typed_res);
    console_res_t res;
    if (idling && $urandom_range(0, 7) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    start     <= 1'b1;
    command   <= cmd;
    char_code <= ch;
    row       <= r;
    col       <= c;
    do @(posedge clk); while (busy);
    res = console_step(cmd, ch, r, c);
    pending_results.push_back(typed ? typed_res : res);
  endtask

  // attribute writes only with nothing open in the block
  task automatic set_attribute(input logic [7:0] value);
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 || busy) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    attr = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int count);
    logic [1:0]       cmd;
    logic [7:0]       ch;
    logic [ROW_W-1:0] r;
    logic [COL_W-1:0] c;
    int               sel;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      r   = ROW_W'($urandom_range(0, 31));
      c   = COL_W'($urandom_range(0, 127));
      ch  = 8'($urandom_range(0, 255));
      if (sel < 2) cmd = CMD_CLEAR;
      else if (sel < 14) cmd = CMD_SETXY;
      else if (sel < 28) cmd = CMD_READ;
      else cmd = CMD_PUT;
      if (cmd == CMD_PUT) begin
        sel = $urandom_range(0, 99);
        if (sel < 10) ch = CH_NEWLINE;
        else if (sel < 15) ch = CH_TAB;
        else if (sel < 21) ch = CH_BACKSPACE;
        else if (sel < 25) ch = CH_RETURN;
      end
      issue(cmd, ch, r, c, 1'b0, '0);
    end
  endtask

  initial begin
    logic [7:0] attr_plan [6];
    attr_plan = '{8'h00, 8'hFF, 8'h0F, 8'h0E, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255))};
    mismatches = 0;
    cur_r  = 0;
    cur_c  = 0;
    attr   = ATTR_RESET;
    idling = 1'b1;
    for (int i = 0; i < CELL_COUNT; i++) screen[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table; the first clear comes before any read
    for (int i = 0; i < PLAN_LEN; i++)
      issue(plan[i].cmd, plan[i].ch, plan[i].r, plan[i].c, plan[i].typed, plan[i].res);

    for (int p = 0; p < 6; p++) begin
      set_attribute(attr_plan[p]);
      idling = (p != 5);
      run_random(238);
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (CELL_COUNT + 16) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // result checker and stall watchdog
  always @(posedge clk) begin
    console_res_t got;
    console_res_t want;
    if (rst) begin
      stall_cycles = 0;
    end else begin
      if (done) begin
        got = '{cursor_row, cursor_col, cursor_position, cell_data, scrolled};
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with nothing pending: row %0d col %0d pos %0d cell %h scr %b",
                     $realtime, got.row, got.col, got.pos, got.cell_val, got.scr);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: mismatch exp row %0d col %0d pos %0d cell %h scr %b",
                        " / got row %0d col %0d pos %0d cell %h scr %b"},
                       $realtime, want.row, want.col, want.pos, want.cell_val, want.scr,
                       got.row, got.col, got.pos, got.cell_val, got.scr);
          end
        end
      end
      if ((start && !busy) || done || (cfg_valid && cfg_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

endmodule

// ===== filelist.f =====
design/tcw_pkg.sv
design/tcw_cursor.sv
design/text_console_writer.sv
test/tb.sv
